// File: sv/twodom_pkg.sv
package twodom_pkg;

    // Input beat: one sample of encoders and gyro
    typedef struct packed {
        logic signed [31:0] left_position;
        logic signed [31:0] right_position;
        logic [15:0]        gyro_angle;
        logic               wheels_present;
    } in_t;

    // Result beat: pose after the sample
    typedef struct packed {
        logic signed [31:0] pose_x_out;
        logic signed [31:0] pose_y_out;
        logic [15:0]        heading_out;
    } out_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL_L_GO,
        ST_MUL_L_WAIT,
        ST_MUL_R_GO,
        ST_MUL_R_WAIT,
        ST_STEP,
        ST_ROT_WAIT,
        ST_MUL_X_GO,
        ST_MUL_X_WAIT,
        ST_MUL_Y_GO,
        ST_MUL_Y_WAIT,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_RADIUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_RADIUS = 1'd1;

    // Wheel scale: radius (Q4.12) times pi/180 in Q32
    localparam int C_W = 43;
    localparam logic [15:0] RADIUS_RESET = 16'd6656;
    localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;
    localparam logic [C_W-1:0] C_RESET = C_W'(RADIUS_RESET) * C_W'(DEG_TO_RAD_Q32);

    // Serial multiplier: multiplier operand consumed one byte per cycle
    localparam int MUL_B_W = 48;
    localparam int MUL_DIGIT_W = 8;
    localparam int MUL_STEPS = MUL_B_W / MUL_DIGIT_W;
    localparam int MUL_CNT_W = 3;

    // Rounding offset for the Q30 products
    localparam logic signed [63:0] ROUND_Q30 = 64'sd536870912;

    // CORDIC
    localparam int CORD_W = 34;
    localparam int CORD_ITERS = 24;
    localparam int CORD_ITER_W = 5;
    localparam logic [29:0] CORD_GAIN_Q30 = 30'd652032874;

    typedef struct packed {
        logic        valid;
        logic        sin_neg;
        logic [31:0] sin_mag;
        logic        cos_neg;
        logic [31:0] cos_mag;
    } rot_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [29:0] atan_turn(input logic [CORD_ITER_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/tracking_wheel_odometry_core.sv
// Dead-reckoning pose tracker for a robot with two tracking wheels and a gyro.
// Input channel s_*: one beat per sample (left/right encoder positions in
// 1/16 degree, gyro heading as a binary angle, wheels-present flag).
// Result channel m_*: one beat per sample with the updated x,y pose (Q24.8
// inches) and the current heading.
// Config port cfg_*: wheel radii in Q4.12 inches; the user must write them
// only while idle, which the block does not enforce. The wheel scale factor
// is formed at the write. Each sample passes load, the two wheel products
// on the serial multiplier (each a start, six byte steps and a finish), step,
// a wait on the 24-step CORDIC that starts at load and runs beside the wheel
// products, the two rotation products, accumulate, emit and idle. A new
// sample is taken only after the block has emitted the last one.
// s_ready is high only between samples. A finished result waits in the output
// register; while the receiver stalls, the next sample is still accepted and
// processed, and the block holds it at the end until the register frees up.
// Reset (aresetn low, synchronous) zeroes the pose, step and previous sample
// state, restores the default radii and holds s_ready low.
module tracking_wheel_odometry_core #(
    parameter int ANGLE_BITS    = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  twodom_pkg::in_t                      s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output twodom_pkg::out_t                     m_data,
    input  logic                                 cfg_we,
    input  logic [twodom_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [twodom_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int AB    = ANGLE_BITS;
    localparam int PB    = POSITION_BITS;
    localparam int MAG_W = PB + 2;
    localparam int A_W   = (MAG_W > 32) ? MAG_W : 32;
    localparam int B_W   = twodom_pkg::MUL_B_W;
    localparam int P_W   = A_W + B_W;
    localparam int R_W   = P_W - 32;
    localparam int F_W   = R_W + 1;
    localparam int S_W   = R_W + 2;
    localparam int CW    = twodom_pkg::C_W;

    twodom_pkg::state_t state_reg, state_next;

    // Configuration and persistent state
    logic [CW-1:0]  c_left_reg, c_right_reg;
    logic [PB-1:0]  prev_left_reg, prev_right_reg;
    logic [AB-1:0]  prev_heading_reg;
    logic [31:0]    forward_step_reg;
    logic [31:0]    pose_x_reg, pose_y_reg;
    logic           m_valid_reg;

    // Per-sample working registers
    twodom_pkg::in_t       in_reg;
    twodom_pkg::out_t      out_reg;
    logic [PB-1:0]         d_l_reg, d_r_reg;
    logic signed [F_W-1:0] fine_l_reg, fine_r_reg;
    logic                  prod_neg_reg;
    logic signed [63:0]    vx_reg, vy_reg;

    // Combinational datapath
    logic [PB-1:0]         pos_l, pos_r;
    logic [AB-1:0]         g_ab, h;
    logic [AB:0]           mid2;
    logic [31:0]           turn;
    logic [PB-1:0]         d_sel, mag;
    logic [MAG_W-1:0]      mag3;
    logic [31:0]           step_mag;
    logic                  step_neg;
    logic                  wheel_neg;
    logic signed [F_W-1:0] r_ext, fine_val;
    logic signed [S_W-1:0] sum, rnd, qsum;
    logic [63:0]           p64;
    logic signed [63:0]    v_val;
    logic signed [63:0]    rx, ry;

    // Unit handshakes
    logic                  mul_start, mul_busy, mul_done;
    logic [A_W-1:0]        mul_a;
    logic [B_W-1:0]        mul_b;
    logic [P_W-1:0]        mul_product;
    logic                  cordic_start;
    twodom_pkg::rot_t      rot;

    twodom_mul #(
        .A_W(A_W)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_product)
    );

    twodom_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .turn    (turn),
        .rot     (rot)
    );

    // Encoder deltas and mid-tick heading
    always_comb begin
        pos_l = PB'($signed(in_reg.left_position));
        pos_r = PB'($signed(in_reg.right_position));
        g_ab  = AB'(in_reg.gyro_angle);
        h     = g_ab - prev_heading_reg;
        mid2  = {prev_heading_reg, 1'b0} + (AB+1)'(h);
        turn  = {mid2, {(31-AB){1'b0}}};
    end

    // Wheel magnitude times the 3/4 gear numerator
    always_comb begin
        d_sel = (state_reg == twodom_pkg::ST_MUL_R_GO) ? d_r_reg : d_l_reg;
        mag   = d_sel[PB-1] ? -d_sel : d_sel;
        mag3  = MAG_W'(mag) + MAG_W'({mag, 1'b0});
    end

    // Signed wheel distance from the >>32 product
    always_comb begin
        wheel_neg = (state_reg == twodom_pkg::ST_MUL_R_WAIT) ? d_r_reg[PB-1] : d_l_reg[PB-1];
        r_ext     = F_W'(mul_product[P_W-1:32]);
        fine_val  = wheel_neg ? -r_ext : r_ext;
    end

    // Average of the wheels, /2^11 rounded half away from zero
    always_comb begin
        sum  = S_W'(fine_l_reg) + S_W'(fine_r_reg);
        rnd  = sum[S_W-1] ? S_W'(1023) : S_W'(1024);
        qsum = sum + rnd;
    end

    // Step magnitude for the rotation products
    always_comb begin
        step_neg = forward_step_reg[31];
        step_mag = step_neg ? -forward_step_reg : forward_step_reg;
        p64      = mul_product[63:0];
        v_val    = prod_neg_reg ? -$signed(p64) : $signed(p64);
        rx       = vx_reg + twodom_pkg::ROUND_Q30;
        ry       = vy_reg + twodom_pkg::ROUND_Q30;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            twodom_pkg::ST_IDLE:       if (s_valid) state_next = twodom_pkg::ST_LOAD;
            twodom_pkg::ST_LOAD:       state_next = twodom_pkg::ST_MUL_L_GO;
            twodom_pkg::ST_MUL_L_GO:   state_next = twodom_pkg::ST_MUL_L_WAIT;
            twodom_pkg::ST_MUL_L_WAIT: if (mul_done) state_next = twodom_pkg::ST_MUL_R_GO;
            twodom_pkg::ST_MUL_R_GO:   state_next = twodom_pkg::ST_MUL_R_WAIT;
            twodom_pkg::ST_MUL_R_WAIT: if (mul_done) state_next = twodom_pkg::ST_STEP;
            twodom_pkg::ST_STEP:       state_next = twodom_pkg::ST_ROT_WAIT;
            twodom_pkg::ST_ROT_WAIT:   if (rot.valid) state_next = twodom_pkg::ST_MUL_X_GO;
            twodom_pkg::ST_MUL_X_GO:   state_next = twodom_pkg::ST_MUL_X_WAIT;
            twodom_pkg::ST_MUL_X_WAIT: if (mul_done) state_next = twodom_pkg::ST_MUL_Y_GO;
            twodom_pkg::ST_MUL_Y_GO:   state_next = twodom_pkg::ST_MUL_Y_WAIT;
            twodom_pkg::ST_MUL_Y_WAIT: if (mul_done) state_next = twodom_pkg::ST_ACCUM;
            twodom_pkg::ST_ACCUM:      state_next = twodom_pkg::ST_EMIT;
            twodom_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_ready) state_next = twodom_pkg::ST_IDLE;
            end
            default:                   state_next = twodom_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and unit operand select
    always_comb begin
        s_ready      = 1'b0;
        cordic_start = 1'b0;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            twodom_pkg::ST_IDLE: s_ready = aresetn;
            twodom_pkg::ST_LOAD: cordic_start = 1'b1;
            twodom_pkg::ST_MUL_L_GO: begin
                mul_start = 1'b1;
                mul_a     = A_W'(mag3);
                mul_b     = B_W'(c_left_reg);
            end
            twodom_pkg::ST_MUL_R_GO: begin
                mul_start = 1'b1;
                mul_a     = A_W'(mag3);
                mul_b     = B_W'(c_right_reg);
            end
            twodom_pkg::ST_MUL_X_GO: begin
                mul_start = 1'b1;
                mul_a     = A_W'(step_mag);
                mul_b     = B_W'(rot.sin_mag);
            end
            twodom_pkg::ST_MUL_Y_GO: begin
                mul_start = 1'b1;
                mul_a     = A_W'(step_mag);
                mul_b     = B_W'(rot.cos_mag);
            end
            default: ;
        endcase
    end

    // Control and persistent state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= twodom_pkg::ST_IDLE;
            c_left_reg       <= twodom_pkg::C_RESET;
            c_right_reg      <= twodom_pkg::C_RESET;
            prev_left_reg    <= '0;
            prev_right_reg   <= '0;
            prev_heading_reg <= '0;
            forward_step_reg <= '0;
            pose_x_reg       <= '0;
            pose_y_reg       <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Radius writes store radius * pi/180 (Q32)
            if (cfg_we) begin
                case (cfg_index)
                    twodom_pkg::REG_LEFT_RADIUS:
                        c_left_reg <= CW'(cfg_wdata) * CW'(twodom_pkg::DEG_TO_RAD_Q32);
                    twodom_pkg::REG_RIGHT_RADIUS:
                        c_right_reg <= CW'(cfg_wdata) * CW'(twodom_pkg::DEG_TO_RAD_Q32);
                    default: ;
                endcase
            end

            if (state_reg == twodom_pkg::ST_LOAD) begin
                prev_left_reg    <= pos_l;
                prev_right_reg   <= pos_r;
                prev_heading_reg <= g_ab;
            end

            // Absent wheels keep the last step
            if (state_reg == twodom_pkg::ST_STEP && in_reg.wheels_present) begin
                forward_step_reg <= qsum[42:11];
            end

            if (state_reg == twodom_pkg::ST_ACCUM) begin
                pose_x_reg <= pose_x_reg + rx[61:30];
                pose_y_reg <= pose_y_reg + ry[61:30];
            end

            // Output register: load on emit, drop once taken
            if (state_reg == twodom_pkg::ST_EMIT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == twodom_pkg::ST_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        if (state_reg == twodom_pkg::ST_LOAD) begin
            d_l_reg <= pos_l - prev_left_reg;
            d_r_reg <= pos_r - prev_right_reg;
        end
        if (state_reg == twodom_pkg::ST_MUL_L_WAIT && mul_done) begin
            fine_l_reg <= fine_val;
        end
        if (state_reg == twodom_pkg::ST_MUL_R_WAIT && mul_done) begin
            fine_r_reg <= fine_val;
        end
        if (state_reg == twodom_pkg::ST_MUL_X_GO) begin
            prod_neg_reg <= step_neg ^ rot.sin_neg;
        end
        if (state_reg == twodom_pkg::ST_MUL_Y_GO) begin
            prod_neg_reg <= step_neg ^ rot.cos_neg;
        end
        if (state_reg == twodom_pkg::ST_MUL_X_WAIT && mul_done) begin
            vx_reg <= v_val;
        end
        if (state_reg == twodom_pkg::ST_MUL_Y_WAIT && mul_done) begin
            vy_reg <= v_val;
        end
        if (state_reg == twodom_pkg::ST_EMIT && (!m_valid_reg || m_ready)) begin
            out_reg.pose_x_out  <= pose_x_reg;
            out_reg.pose_y_out  <= pose_y_reg;
            out_reg.heading_out <= 16'(g_ab);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // An accepted beat always starts a new sample
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == twodom_pkg::ST_LOAD))
        else $error("accepted beat did not start processing");

    // The shared multiplier is never restarted mid-product
    a_mul_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    // Rotation products only use a finished CORDIC result
    a_rot_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == twodom_pkg::ST_MUL_X_GO || state_reg == twodom_pkg::ST_MUL_Y_GO)
        |-> rot.valid)
        else $error("rotation product started before CORDIC finished");

    // A pending result is never overwritten by the next sample
    a_emit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == twodom_pkg::ST_EMIT && m_valid_reg && !m_ready)
        |=> (state_reg == twodom_pkg::ST_EMIT && m_valid_reg))
        else $error("result emitted over a pending beat");

endmodule

// File: sv/twodom_mul.sv
module twodom_mul #(
    parameter int A_W = 34
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    start,
    input  logic [A_W-1:0]                          a,
    input  logic [twodom_pkg::MUL_B_W-1:0]          b,
    output logic                                    busy,
    output logic                                    done,
    output logic [A_W+twodom_pkg::MUL_B_W-1:0]      product
);

    localparam int B_W = twodom_pkg::MUL_B_W;
    localparam int DW = twodom_pkg::MUL_DIGIT_W;
    localparam int P_W = A_W + B_W;
    localparam int CW = twodom_pkg::MUL_CNT_W;

    logic [A_W-1:0]    a_reg;
    logic [P_W-1:0]    p_reg;
    logic [P_W-1:0]    p_next;
    logic [A_W+DW-1:0] acc;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // One byte of b per cycle, LSB first; finished low bits shift out below
    always_comb begin
        acc = (A_W+DW)'(p_reg[P_W-1:B_W])
            + (A_W+DW)'(a_reg) * (A_W+DW)'(p_reg[DW-1:0]);
        p_next = {acc, p_reg[B_W-1:DW]};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(twodom_pkg::MUL_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Operand and partial product
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= {A_W'(0), b};
        end else if (busy_reg) begin
            p_reg <= p_next;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = p_reg;

endmodule

// File: sv/twodom_cordic.sv
module twodom_cordic (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [31:0]        turn,
    output twodom_pkg::rot_t   rot
);

    localparam int XW = twodom_pkg::CORD_W;
    localparam int IW = twodom_pkg::CORD_ITER_W;

    logic signed [XW-1:0] x_reg, y_reg, z_reg;
    logic signed [XW-1:0] x_next, y_next, z_next;
    logic signed [XW-1:0] dx, dy, da;
    logic signed [XW-1:0] y_abs, x_abs;
    logic [31:0]          t_probe, t_fold;
    logic                 fold;
    logic                 flip_reg;
    logic [IW-1:0]        iter_reg;
    logic                 busy_reg;
    logic                 valid_reg;

    // Half-turn fold keeps the start angle within a quarter turn of zero
    always_comb begin
        t_probe = turn + 32'h4000_0000;
        fold    = t_probe[31];
        t_fold  = fold ? (turn ^ 32'h8000_0000) : turn;
    end

    // One rotation step: arithmetic shifts and three add/subtracts
    always_comb begin
        dx = y_reg >>> iter_reg;
        dy = x_reg >>> iter_reg;
        da = XW'($signed({1'b0, twodom_pkg::atan_turn(iter_reg)}));
        if (!z_reg[XW-1]) begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - da;
        end else begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + da;
        end
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            iter_reg  <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            iter_reg  <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + IW'(1);
            if (iter_reg == IW'(twodom_pkg::CORD_ITERS - 1)) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
    end

    // Vector and residual angle
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= XW'($signed({1'b0, twodom_pkg::CORD_GAIN_Q30}));
            y_reg    <= '0;
            z_reg    <= XW'($signed(t_fold));
            flip_reg <= fold;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // Sign and magnitude of sin and cos; the fold flips both signs
    always_comb begin
        y_abs = y_reg[XW-1] ? -y_reg : y_reg;
        x_abs = x_reg[XW-1] ? -x_reg : x_reg;
        rot.valid   = valid_reg;
        rot.sin_neg = y_reg[XW-1] ^ flip_reg;
        rot.sin_mag = y_abs[31:0];
        rot.cos_neg = x_reg[XW-1] ^ flip_reg;
        rot.cos_mag = x_abs[31:0];
    end

endmodule
